// File: rtl/nsc_pkg.sv
// ----------------------------------------------------------------------------
// nsc_pkg: shared types and constants of the nibble calendar clock
// Holds the command and status structs and the port mode codes.
// ----------------------------------------------------------------------------
package nsc_pkg;

    localparam logic [1:0] PM_READ    = 2'd0;
    localparam logic [1:0] PM_COMMAND = 2'd1;
    localparam logic [1:0] PM_LOAD    = 2'd2;
    localparam logic [1:0] PM_IDLE    = 2'd3;

    localparam logic [1:0] MD_READ  = 2'd0;
    localparam logic [1:0] MD_WRITE = 2'd1;
    localparam logic [1:0] MD_TICK  = 2'd2;

    localparam logic [3:0] NB_READ  = 4'd13;
    localparam logic [3:0] NB_CMD   = 4'd14;
    localparam logic [3:0] NB_NOP   = 4'd15;
    localparam logic [3:0] CMD_LOAD = 4'd0;
    localparam logic [3:0] CMD_CLR  = 4'd4;

    localparam int unsigned NDIG = 13;

    typedef struct packed {
        logic       start;    // start a word: latch mode and data from the command
        logic [1:0] mode;
        logic [3:0] data;
    } t_cmd;

    typedef struct packed {
        logic       done;
        logic [3:0] rdata;
    } t_sts;

endpackage

// File: rtl/nsc_datapath.sv
// ----------------------------------------------------------------------------
// nsc_datapath: calendar storage and arithmetic
// Executes one port word in phases: decode, capture, validity check,
// normalise, store, weekday and latch.
// ----------------------------------------------------------------------------
module nsc_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  nsc_pkg::t_cmd i_cmd,
    output nsc_pkg::t_sts o_sts
);

    logic [3:0] r_cal [13];
    logic [3:0] r_lat [13];
    logic [1:0] r_pm;
    logic [3:0] r_pos;
    logic       r_pv;
    // phase: 0 idle, 1 decode, 2 capture, 3 check, 4 carry, 5 store, 6 weekday, 7 latch
    logic [2:0] r_ph;
    logic [1:0] r_md;
    logic [3:0] r_dt;
    logic       r_adv;  // normalise pending
    logic       r_ext;  // extra second
    logic       r_wd;   // weekday only
    logic [3:0] r_rd;

    // stage registers for the arithmetic
    logic [7:0]  r_s, r_mi, r_h, r_d;
    logic [3:0]  r_mo;
    logic [10:0] r_yo;
    logic        r_tok;
    logic        r_ok;
    logic [4:0]  r_ml;
    logic [11:0] r_wy;
    logic [5:0]  r_wq;

    // values of current digits
    logic [7:0]  w_s, w_mi, w_h, w_d;
    logic [10:0] w_yo;

    function automatic logic [4:0] f_mlen(input logic [3:0] m, input logic leap);
        case (m)
            4'd2:                        f_mlen = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:     f_mlen = 5'd30;
            default:                     f_mlen = 5'd31;
        endcase
    endfunction

    // quotient by 100 through reciprocal multiplication, exact below 4681
    function automatic logic [5:0] f_div100(input logic [11:0] y);
        logic [22:0] p;
        begin
            p = 23'(y) * 23'd1311;
            f_div100 = p[22:17];
        end
    endfunction

    // quotient by 10, exact below 1024
    function automatic logic [3:0] f_div10(input logic [6:0] v);
        logic [14:0] p;
        begin
            p = 15'(v) * 15'd205;
            f_div10 = p[14:11];
        end
    endfunction

    // remainder by 7, exact below 13107
    function automatic logic [2:0] f_mod7(input logic [11:0] x);
        logic [25:0] p;
        logic [11:0] r;
        begin
            p = 26'(x) * 26'd9363;
            r = x - 12'(p[25:16]) * 12'd7;
            f_mod7 = r[2:0];
        end
    endfunction

    function automatic logic f_leap(input logic [11:0] y);
        logic [5:0] q;
        logic       z;
        begin
            q = f_div100(y);
            z = (12'(q) * 12'd100) == y;
            f_leap = (y[1:0] == 2'd0 && !z) || (z && q[1:0] == 2'd0);
        end
    endfunction

    always_comb begin
        w_s  = {4'd0, r_cal[0]} + 8'(r_cal[1]) * 8'd10;
        w_mi = {4'd0, r_cal[2]} + 8'(r_cal[3]) * 8'd10;
        w_h  = {4'd0, r_cal[4]} + 8'(r_cal[5]) * 8'd10;
        w_d  = {4'd0, r_cal[6]} + 8'(r_cal[7]) * 8'd10;
        w_yo = 11'(r_cal[9]) + 11'(r_cal[10]) * 11'd10 + 11'(r_cal[11]) * 11'd100;
    end

    // date check on captured values
    logic       w_leap;
    logic [4:0] w_ml;
    logic       w_dok;
    always_comb begin
        w_leap = f_leap(12'(r_yo) + 12'd1000);
        w_ml   = f_mlen(r_mo, w_leap);
        w_dok  = (r_mo >= 4'd1) && (r_mo <= 4'd12) && (r_d >= 8'd1)
                 && (r_d <= {3'd0, w_ml});
    end

    // carry chain on registered values
    logic [7:0]  c_s, c_mi, c_h, c_d;
    logic [3:0]  c_mo;
    logic [10:0] c_yo;
    always_comb begin
        c_s = r_s; c_mi = r_mi; c_h = r_h; c_d = r_d; c_mo = r_mo; c_yo = r_yo;
        if (r_ext) begin
            c_s = r_s + 8'd1;
            if (c_s >= 8'd60) begin
                c_s = 8'd0; c_mi = r_mi + 8'd1;
                if (c_mi >= 8'd60) begin
                    c_mi = 8'd0; c_h = r_h + 8'd1;
                    if (c_h >= 8'd24) begin
                        c_h = 8'd0; c_d = r_d + 8'd1;
                        if (c_d > {3'd0, r_ml}) begin
                            c_d = 8'd1; c_mo = r_mo + 4'd1;
                            if (c_mo > 4'd12) begin
                                c_mo = 4'd1; c_yo = r_yo + 11'd1;
                            end
                        end
                    end
                end
            end
        end
        if (c_yo >= 11'd1600) c_yo = c_yo - 11'd1600;
    end

    // digit split of the carried values
    logic [3:0]  w_sq, w_miq, w_hq, w_dq, w_yh, w_y2q;
    logic [6:0]  w_y2;
    logic [11:0] w_wy;
    always_comb begin
        w_sq  = f_div10(r_s[6:0]);
        w_miq = f_div10(r_mi[6:0]);
        w_hq  = f_div10(r_h[6:0]);
        w_dq  = f_div10(r_d[6:0]);
        w_yh  = 4'(f_div100(12'(r_yo)));
        w_y2  = 7'(r_yo - 11'(w_yh) * 11'd100);
        w_y2q = f_div10(w_y2);
        w_wy  = 12'(r_yo) + 12'd1000 - ((r_mo < 4'd3) ? 12'd1 : 12'd0);
    end

    // weekday from registered date
    logic [3:0]  w_key;
    logic [11:0] w_sum;
    logic [2:0]  w_wk;
    always_comb begin
        case (r_mo)
            4'd1:  w_key = 4'd0;
            4'd2:  w_key = 4'd3;
            4'd3:  w_key = 4'd2;
            4'd4:  w_key = 4'd5;
            4'd5:  w_key = 4'd0;
            4'd6:  w_key = 4'd3;
            4'd7:  w_key = 4'd5;
            4'd8:  w_key = 4'd1;
            4'd9:  w_key = 4'd4;
            4'd10: w_key = 4'd6;
            4'd11: w_key = 4'd2;
            4'd12: w_key = 4'd4;
            default: w_key = 4'd0;
        endcase
        w_sum = r_wy + (r_wy >> 2) - 12'(r_wq) + 12'(r_wq >> 2) + 12'(w_key) + 12'(r_d);
        w_wk  = f_mod7(w_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 13; k++) begin
                r_cal[k] <= 4'd0;
                r_lat[k] <= 4'd0;
            end
            r_pm  <= nsc_pkg::PM_READ;
            r_pos <= 4'd0;
            r_pv  <= 1'b0;
            r_ph  <= 3'd0;
        end else begin
            case (r_ph)
                3'd0: begin
                    if (i_cmd.start) begin
                        r_md <= i_cmd.mode;
                        r_dt <= i_cmd.data;
                        r_ph <= 3'd1;
                    end
                end
                3'd1: begin
                    r_adv <= 1'b0; r_ext <= 1'b0; r_wd <= 1'b0; r_rd <= 4'd0;
                    r_ph  <= 3'd2;
                    case (r_md)
                        nsc_pkg::MD_READ: begin
                            if (r_pm == nsc_pkg::PM_READ) begin
                                if (!r_pv) begin
                                    r_adv <= 1'b1; r_pos <= 4'd0; r_pv <= 1'b1;
                                    r_rd <= 4'd15;
                                end else if (r_pos >= 4'd13) begin
                                    r_pv <= 1'b0; r_pos <= 4'd0; r_rd <= 4'd15;
                                end else begin
                                    r_rd <= r_lat[r_pos]; r_pos <= r_pos + 4'd1;
                                end
                            end
                        end
                        nsc_pkg::MD_WRITE: begin
                            if (r_dt == nsc_pkg::NB_READ) begin
                                r_pm <= nsc_pkg::PM_READ; r_pv <= 1'b0; r_pos <= 4'd0;
                            end else if (r_dt == nsc_pkg::NB_CMD) begin
                                r_pm <= nsc_pkg::PM_COMMAND;
                            end else if (r_dt == nsc_pkg::NB_NOP) begin
                            end else if (r_pm == nsc_pkg::PM_COMMAND) begin
                                r_pos <= 4'd0;
                                if (r_dt == nsc_pkg::CMD_LOAD) begin
                                    r_pm <= nsc_pkg::PM_LOAD; r_pv <= 1'b1;
                                end else begin
                                    r_pm <= nsc_pkg::PM_IDLE; r_pv <= 1'b0;
                                    if (r_dt == nsc_pkg::CMD_CLR)
                                        for (int k = 0; k < 13; k++) r_cal[k] <= 4'd0;
                                end
                            end else if (r_pm == nsc_pkg::PM_LOAD && r_pv
                                         && r_pos < 4'd12) begin
                                r_cal[r_pos] <= r_dt;
                                r_pos <= r_pos + 4'd1;
                                if (r_pos == 4'd11) r_wd <= 1'b1;
                            end
                        end
                        nsc_pkg::MD_TICK: begin
                            if (!(r_pm == nsc_pkg::PM_LOAD && r_pv && r_pos < 4'd12)) begin
                                r_adv <= 1'b1; r_ext <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                3'd2: begin
                    r_s  <= w_s;  r_mi <= w_mi;
                    r_h  <= w_h;  r_d  <= w_d;
                    r_mo <= r_cal[8];  r_yo <= w_yo;
                    r_tok <= (w_s < 8'd60) && (w_mi < 8'd60) && (w_h < 8'd24);
                    r_ph <= 3'd3;
                end
                3'd3: begin
                    r_ok <= w_dok && (r_adv ? r_tok : r_wd);
                    r_ml <= w_ml;
                    r_ph <= 3'd4;
                end
                3'd4: begin
                    r_s  <= c_s; r_mi <= c_mi; r_h <= c_h;
                    r_d  <= c_d; r_mo <= c_mo; r_yo <= c_yo;
                    r_ph <= 3'd5;
                end
                3'd5: begin
                    if (r_ok && r_adv) begin
                        r_cal[0] <= 4'(r_s - 8'(w_sq) * 8'd10);   r_cal[1] <= w_sq;
                        r_cal[2] <= 4'(r_mi - 8'(w_miq) * 8'd10); r_cal[3] <= w_miq;
                        r_cal[4] <= 4'(r_h - 8'(w_hq) * 8'd10);   r_cal[5] <= w_hq;
                        r_cal[6] <= 4'(r_d - 8'(w_dq) * 8'd10);   r_cal[7] <= w_dq;
                        r_cal[8] <= r_mo;
                        r_cal[9] <= 4'(w_y2 - 7'(w_y2q) * 7'd10); r_cal[10] <= w_y2q;
                        r_cal[11] <= w_yh;
                    end
                    r_wy <= w_wy;
                    r_wq <= f_div100(w_wy);
                    r_ph <= 3'd6;
                end
                3'd6: begin
                    if (r_ok) r_cal[12] <= {1'b0, w_wk};
                    r_ph <= 3'd7;
                end
                default: begin
                    if (r_adv && r_md == nsc_pkg::MD_READ)
                        for (int k = 0; k < 13; k++) r_lat[k] <= r_cal[k];
                    r_ph <= 3'd0;
                end
            endcase
        end
    end

    assign o_sts.done  = (r_ph == 3'd7);
    assign o_sts.rdata = r_rd;

endmodule

// File: rtl/nsc_control.sv
// ----------------------------------------------------------------------------
// nsc_control: handshake controller
// Accepts one word, starts the datapath and holds the result for the output.
// ----------------------------------------------------------------------------
module nsc_control (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_mode,
    input  logic [3:0]    i_write_data,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [3:0]    o_read_data,
    output nsc_pkg::t_cmd o_cmd,
    input  nsc_pkg::t_sts i_sts
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BUSY = 2'd1;

    logic [1:0] r_state, n_state;
    logic       r_ov;
    logic [3:0] r_od;

    assign o_ready = (r_state == S_IDLE) && !r_ov;
    assign o_cmd.start = i_valid && o_ready;
    assign o_cmd.mode  = i_mode;
    assign o_cmd.data  = i_write_data;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (o_cmd.start) n_state = S_BUSY;
            S_BUSY:  if (i_sts.done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_sts.done) begin
                r_ov <= 1'b1;
                r_od <= i_sts.rdata;
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid     = r_ov;
    assign o_read_data = r_od;

endmodule

// File: rtl/nibble_serial_calendar_clock_unit.sv
// ----------------------------------------------------------------------------
// nibble_serial_calendar_clock_unit: calendar clock behind a nibble port
// channel | handshake           | payload
// input   | i_valid / o_ready   | i_mode, i_write_data
// output  | o_valid / i_ready   | o_read_data
// Each word passes from acceptance to result through the datapath phase
// sequence (decode, capture, check, carry, store, weekday, latch). The
// next word is taken the cycle after the result has been taken, so one
// word is in flight at a time; output stalls delay the next word.
// Synchronous active-low reset clears the calendar and the port state.
// ----------------------------------------------------------------------------
module nibble_serial_calendar_clock_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_mode,
    input  logic [3:0] i_write_data,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_read_data
);

    nsc_pkg::t_cmd w_cmd;
    nsc_pkg::t_sts w_sts;

    nsc_control u_ctl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_mode, .i_write_data,
        .o_valid, .i_ready, .o_read_data, .o_cmd(w_cmd), .i_sts(w_sts)
    );

    nsc_datapath u_dp (.i_clk, .i_rst_n, .i_cmd(w_cmd), .o_sts(w_sts));

endmodule

// File: tb/sv/nibble_serial_calendar_clock_unit_checker.sv
// ----------------------------------------------------------------------------
// nibble_serial_calendar_clock_unit_checker: result predictor and comparator
// Watches both channels of the calendar clock, models the digits, the port
// state and the one-second advance, and compares each returned nibble with
// the oldest predicted one.
// ----------------------------------------------------------------------------
module nibble_serial_calendar_clock_unit_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_ready_in,
    input  logic [1:0] i_mode,
    input  logic [3:0] i_write_data,
    input  logic       i_out_valid,
    input  logic       i_ready,
    input  logic [3:0] i_read_data,
    output int         o_errors,
    output int         o_pending,
    output int         o_words_in,
    output int         o_words_out
);

    logic [3:0] clk_digits [nsc_pkg::NDIG];
    logic [3:0] snap_digits [nsc_pkg::NDIG];
    logic [1:0] port_state;
    logic [3:0] read_pos;
    logic       pos_live;
    logic [3:0] nibble_queue [$];

    function automatic bit leap_year(int unsigned y);
        return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
    endfunction

    function automatic int unsigned days_in(int unsigned y, int unsigned m);
        int unsigned len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m == 2 && leap_year(y)) return 29;
        return len[(m - 1) % 12];
    endfunction

    function automatic logic [3:0] weekday(int unsigned y, int unsigned m, int unsigned d);
        int unsigned key [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
        if (m < 3) y = y - 1;
        return 4'((y + y / 4 - y / 100 + y / 400 + key[(m - 1) % 12] + d) % 7);
    endfunction

    function automatic int unsigned two(int lo);
        return clk_digits[lo] + 10 * clk_digits[lo + 1];
    endfunction

    function automatic int unsigned yr_ofs();
        return clk_digits[9] + 10 * clk_digits[10] + 100 * clk_digits[11];
    endfunction

    function automatic bit date_valid();
        int unsigned m;
        int unsigned d;
        m = clk_digits[8];
        d = two(6);
        if (m < 1 || m > 12) return 0;
        return d >= 1 && d <= days_in(1000 + yr_ofs(), m);
    endfunction

    function automatic void store_two(int lo, int unsigned v);
        clk_digits[lo]     = 4'(v % 10);
        clk_digits[lo + 1] = 4'((v / 10) & 15);
    endfunction

    function automatic void step_clock(int unsigned extra);
        int unsigned s, mi, h, d, mo, yo;
        s  = two(0);
        mi = two(2);
        h  = two(4);
        d  = two(6);
        mo = clk_digits[8];
        yo = yr_ofs();
        if (!date_valid() || s >= 60 || mi >= 60 || h >= 24) return;
        s += extra;
        if (s >= 60) begin
            s = 0;
            mi++;
            if (mi >= 60) begin
                mi = 0;
                h++;
                if (h >= 24) begin
                    h = 0;
                    d++;
                    if (d > days_in(1000 + yo, mo)) begin
                        d = 1;
                        mo++;
                        if (mo > 12) begin
                            mo = 1;
                            yo++;
                        end
                    end
                end
            end
        end
        while (yo >= 1600) yo -= 1600;
        store_two(0, s);
        store_two(2, mi);
        store_two(4, h);
        store_two(6, d);
        clk_digits[8]  = 4'(mo);
        store_two(9, yo % 100);
        clk_digits[11] = 4'(yo / 100);
        clk_digits[12] = weekday(1000 + yo, mo, d);
    endfunction

    function automatic logic [3:0] take_read();
        logic [3:0] r;
        if (port_state != nsc_pkg::PM_READ) return 4'd0;
        if (!pos_live) begin
            step_clock(0);
            snap_digits = clk_digits;
            read_pos = 0;
            pos_live = 1;
            return 4'd15;
        end
        if (read_pos >= 13) begin
            pos_live = 0;
            read_pos = 0;
            return 4'd15;
        end
        r = snap_digits[read_pos];
        read_pos++;
        return r;
    endfunction

    function automatic void take_write(logic [3:0] v);
        if (v == nsc_pkg::NB_READ) begin
            port_state = nsc_pkg::PM_READ;
            pos_live = 0;
            read_pos = 0;
        end else if (v == nsc_pkg::NB_CMD) begin
            port_state = nsc_pkg::PM_COMMAND;
        end else if (v == nsc_pkg::NB_NOP) begin
        end else if (port_state == nsc_pkg::PM_COMMAND) begin
            read_pos = 0;
            if (v == nsc_pkg::CMD_LOAD) begin
                port_state = nsc_pkg::PM_LOAD;
                pos_live = 1;
            end else begin
                port_state = nsc_pkg::PM_IDLE;
                pos_live = 0;
                if (v == nsc_pkg::CMD_CLR) foreach (clk_digits[i]) clk_digits[i] = 0;
            end
        end else if (port_state == nsc_pkg::PM_LOAD && pos_live && read_pos < 12) begin
            clk_digits[read_pos] = v;
            read_pos++;
            if (read_pos == 12 && date_valid())
                clk_digits[12] = weekday(1000 + yr_ofs(), clk_digits[8], two(6));
        end
    endfunction

    function automatic logic [3:0] predict_nibble(logic [1:0] md, logic [3:0] wd);
        logic [3:0] r;
        r = 0;
        if (md == nsc_pkg::MD_READ) r = take_read();
        else if (md == nsc_pkg::MD_WRITE) take_write(wd);
        else if (md == nsc_pkg::MD_TICK) begin
            if (!(port_state == nsc_pkg::PM_LOAD && pos_live && read_pos < 12))
                step_clock(1);
        end
        return r;
    endfunction

    assign o_pending = nibble_queue.size();

    always @(posedge i_clk) begin
        logic [3:0] want;
        if (!i_rst_n) begin
            foreach (clk_digits[i]) begin
                clk_digits[i]  = 0;
                snap_digits[i] = 0;
            end
            port_state = nsc_pkg::PM_READ;
            read_pos = 0;
            pos_live = 0;
            nibble_queue.delete();
            o_errors <= 0;
            o_words_in <= 0;
            o_words_out <= 0;
        end else begin
            if (i_out_valid && i_ready) begin
                o_words_out <= o_words_out + 1;
                if (nibble_queue.size() == 0) begin
                    if (o_errors < 10) $display("unexpected word: got %0d", i_read_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = nibble_queue.pop_front();
                    if (want !== i_read_data) begin
                        if (o_errors < 10)
                            $display("mismatch on read_data: expected %0d got %0d",
                                     want, i_read_data);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && i_ready_in) begin
                o_words_in <= o_words_in + 1;
                nibble_queue.push_back(predict_nibble(i_mode, i_write_data));
            end
        end
    end

endmodule

// File: tb/sv/nibble_serial_calendar_clock_unit_test.sv
// ----------------------------------------------------------------------------
// nibble_serial_calendar_clock_unit_test: stimulus and verdict
// Drives reads, writes, loads and ticks into the calendar clock through
// phases of sender and receiver idling; a checker beside the block compares
// every returned nibble.
// ----------------------------------------------------------------------------
module nibble_serial_calendar_clock_unit_test;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [1:0] i_mode;
    logic [3:0] i_write_data;
    logic       o_valid;
    logic       i_ready;
    logic [3:0] o_read_data;
    int         errors;
    int         pending;
    int         words_in;
    int         words_out;
    int         idle_pct;
    int         stall_pct;
    int         quiet;
    int         loads_sent;

    nibble_serial_calendar_clock_unit DUT (.*);

    nibble_serial_calendar_clock_unit_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_mode(i_mode), .i_write_data(i_write_data), .i_out_valid(o_valid),
        .i_ready(i_ready), .i_read_data(o_read_data), .o_errors(errors),
        .o_pending(pending), .o_words_in(words_in), .o_words_out(words_out)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 0;
        else i_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_word(logic [1:0] md, logic [3:0] wd);
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
        i_valid <= 1;
        i_mode <= md;
        i_write_data <= wd;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic load_date(int unsigned s, int unsigned mi, int unsigned h,
                             int unsigned d, int unsigned mo, int unsigned yo);
        send_word(nsc_pkg::MD_WRITE, nsc_pkg::NB_CMD);
        send_word(nsc_pkg::MD_WRITE, nsc_pkg::CMD_LOAD);
        send_word(nsc_pkg::MD_WRITE, 4'(s % 10));
        send_word(nsc_pkg::MD_WRITE, 4'(s / 10));
        send_word(nsc_pkg::MD_WRITE, 4'(mi % 10));
        send_word(nsc_pkg::MD_WRITE, 4'(mi / 10));
        send_word(nsc_pkg::MD_WRITE, 4'(h % 10));
        send_word(nsc_pkg::MD_WRITE, 4'(h / 10));
        send_word(nsc_pkg::MD_WRITE, 4'(d % 10));
        send_word(nsc_pkg::MD_WRITE, 4'(d / 10));
        send_word(nsc_pkg::MD_WRITE, 4'(mo));
        send_word(nsc_pkg::MD_WRITE, 4'(yo % 10));
        send_word(nsc_pkg::MD_WRITE, 4'((yo / 10) % 10));
        send_word(nsc_pkg::MD_WRITE, 4'(yo / 100));
        loads_sent++;
    endtask

    task automatic read_all();
        send_word(nsc_pkg::MD_WRITE, nsc_pkg::NB_READ);
        repeat (15) send_word(nsc_pkg::MD_READ, 4'($urandom_range(15)));
    endtask

    initial begin
        int phase;
        int n;
        i_rst_n = 0;
        i_valid = 0;
        i_mode = 0;
        i_write_data = 0;
        idle_pct = 0;
        stall_pct = 0;
        quiet = 0;
        loads_sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: end of century, into leap day, clear, bad date
        load_date(59, 59, 23, 31, 12, 1599);
        send_word(nsc_pkg::MD_TICK, 4'd0);
        read_all();
        load_date(59, 59, 23, 28, 2, 1000);
        send_word(nsc_pkg::MD_TICK, 4'd0);
        send_word(nsc_pkg::MD_TICK, 4'd0);
        read_all();
        send_word(nsc_pkg::MD_WRITE, nsc_pkg::NB_CMD);
        send_word(nsc_pkg::MD_WRITE, nsc_pkg::CMD_CLR);
        send_word(nsc_pkg::MD_TICK, 4'd0);
        send_word(nsc_pkg::MD_READ, 4'd0);
        send_word(2'd3, 4'hf);
        send_word(nsc_pkg::MD_WRITE, nsc_pkg::NB_NOP);
        read_all();

        for (phase = 0; phase < 4; phase++) begin
            idle_pct  = (phase == 1) ? 46 : (phase == 3) ? 27 : 0;
            stall_pct = (phase == 2) ? 46 : (phase == 3) ? 27 : 0;
            n = 0;
            while (n < 125) begin
                case ($urandom_range(9))
                    0, 1, 2: begin
                        load_date($urandom_range(59), $urandom_range(59), $urandom_range(23),
                                  $urandom_range(1, 31), $urandom_range(1, 12),
                                  $urandom_range(1599));
                        n += 14;
                    end
                    3, 4: begin
                        read_all();
                        n += 16;
                    end
                    5, 6: begin
                        repeat (4) send_word(nsc_pkg::MD_TICK, 4'($urandom_range(15)));
                        n += 4;
                    end
                    default: begin
                        send_word(2'($urandom_range(3)), 4'($urandom_range(15)));
                        n += 1;
                    end
                endcase
            end
        end
        i_valid <= 0;
        idle_pct = 0;
        stall_pct = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("covered %0d words in, %0d out, %0d date loads over four idling phases",
                 words_in, words_out, loads_sent);
        if (errors == 0 && pending == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
